// ===== hdl/linear_setpoint_trajectory_assert.svh =====
// Assertion macros shared by the linear setpoint trajectory RTL.
// Users of these macros must have signals named clk and rst in scope.
`ifndef LINEAR_SETPOINT_TRAJECTORY_ASSERT_SVH
`define LINEAR_SETPOINT_TRAJECTORY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("linear_setpoint_trajectory: assertion failed");

// Next-cycle implication, checked outside reset.
`define LST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("linear_setpoint_trajectory: assertion failed");

`endif

// ===== hdl/lst_pkg.sv =====
// Shared widths, constants, types and helpers for the setpoint trajectory block.
// No dependencies.
package lst_pkg;

  localparam int TGT_W  = 32;
  localparam int SP_W   = 40;
  localparam int STEP_W = 16;
  localparam int IDX_W  = 2;
  localparam int Q_FRAC = 8;
  localparam int DIFF_W = TGT_W + Q_FRAC + 1;
  localparam int ACC_W  = DIFF_W + STEP_W + 1;
  localparam int DCNT_W = 6;

  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIFF_W - 1);

  localparam logic [DIFF_W-1:0] LIMIT_SHORT  = DIFF_W'(5000 << Q_FRAC);
  localparam logic [DIFF_W-1:0] LIMIT_MEDIUM = DIFF_W'(15000 << Q_FRAC);
  localparam logic [DIFF_W-1:0] LIMIT_LONG   = DIFF_W'(35000 << Q_FRAC);

  localparam logic [STEP_W-1:0] STEP_COUNT_RESET   = 16'd100;
  localparam logic [STEP_W-1:0] SHORT_STEPS_RESET  = 16'd600;
  localparam logic [STEP_W-1:0] MEDIUM_STEPS_RESET = 16'd1200;
  localparam logic [STEP_W-1:0] LONG_STEPS_RESET   = 16'd2000;

  localparam logic [IDX_W-1:0] REG_SHORT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MEDIUM = 2'd1;
  localparam logic [IDX_W-1:0] REG_LONG   = 2'd2;

  localparam logic signed [SP_W-1:0] SP_MAX = {1'b0, {(SP_W-1){1'b1}}};
  localparam logic signed [SP_W-1:0] SP_MIN = {1'b1, {(SP_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic prep;
    logic sel;
    logic div_step;
    logic div_fin;
    logic mload;
    logic mstep;
    logic fin;
  } lst_cmd_t;

  typedef struct packed {
    logic restart;
    logic div_last;
    logic mul_done;
  } lst_sts_t;

  function automatic logic [STEP_W-1:0] at_least_one(input logic [STEP_W-1:0] v);
    return (v == '0) ? STEP_W'(1) : v;
  endfunction

endpackage

// ===== hdl/lst_dpath.sv =====
// Datapath of the setpoint trajectory: ramp state, bit-serial divider and
// shift-add multiplier. Depends on lst_pkg.
module lst_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  lst_pkg::lst_cmd_t                cmd,
  output lst_pkg::lst_sts_t                sts,
  input  logic signed [lst_pkg::TGT_W-1:0] target_position,
  input  logic                             cfg_valid,
  input  logic [lst_pkg::IDX_W-1:0]        cfg_index,
  input  logic [lst_pkg::STEP_W-1:0]       cfg_data,
  output logic signed [lst_pkg::SP_W-1:0]  setpoint,
  output logic [lst_pkg::STEP_W-1:0]       tick_index
);

  logic [lst_pkg::STEP_W-1:0] short_steps;
  logic [lst_pkg::STEP_W-1:0] medium_steps;
  logic [lst_pkg::STEP_W-1:0] long_steps;

  logic [lst_pkg::TGT_W-1:0]  target;
  logic [lst_pkg::TGT_W-1:0]  seen_target;
  logic [lst_pkg::SP_W-1:0]   ramp_start;
  logic [lst_pkg::SP_W-1:0]   current_setpoint;
  logic [lst_pkg::DIFF_W-1:0] step_increment;
  logic [lst_pkg::STEP_W-1:0] step_count;
  logic [lst_pkg::STEP_W-1:0] tick_counter;

  logic [lst_pkg::DIFF_W-1:0] diff;
  logic                       diff_neg;
  logic [lst_pkg::DIFF_W-1:0] dq;
  logic [lst_pkg::STEP_W-1:0] rem;
  logic [lst_pkg::DCNT_W-1:0] dcnt;
  logic [lst_pkg::ACC_W-1:0]  acc;
  logic [lst_pkg::ACC_W-1:0]  mcand;
  logic [lst_pkg::STEP_W-1:0] mplier;

  logic [lst_pkg::DIFF_W-1:0] diff_next;
  logic [lst_pkg::DIFF_W-1:0] mag;
  logic [lst_pkg::STEP_W-1:0] count_sel;
  logic [lst_pkg::STEP_W-1:0] tick_next;
  logic [lst_pkg::STEP_W:0]   rem_shift;
  logic                       rem_ge;
  logic [lst_pkg::SP_W-1:0]   sat;
  logic [lst_pkg::ACC_W-lst_pkg::SP_W:0] acc_hi;

  always_comb begin
    diff_next = {target[lst_pkg::TGT_W-1], target, {lst_pkg::Q_FRAC{1'b0}}}
              - {current_setpoint[lst_pkg::SP_W-1], current_setpoint};
    mag = diff[lst_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
    if (mag <= lst_pkg::LIMIT_SHORT) begin
      count_sel = lst_pkg::at_least_one(short_steps);
    end else if (mag <= lst_pkg::LIMIT_MEDIUM) begin
      count_sel = lst_pkg::at_least_one(medium_steps);
    end else if (mag <= lst_pkg::LIMIT_LONG) begin
      count_sel = lst_pkg::at_least_one(long_steps);
    end else begin
      count_sel = lst_pkg::at_least_one(step_count);
    end
    tick_next = (tick_counter >= step_count) ? step_count : tick_counter + 1'b1;
    rem_shift = {rem, dq[lst_pkg::DIFF_W-1]};
    rem_ge    = rem_shift >= {1'b0, step_count};
    acc_hi    = acc[lst_pkg::ACC_W-1:lst_pkg::SP_W-1];
    if (acc_hi == '0 || acc_hi == '1) begin
      sat = acc[lst_pkg::SP_W-1:0];
    end else if (acc[lst_pkg::ACC_W-1]) begin
      sat = lst_pkg::SP_MIN;
    end else begin
      sat = lst_pkg::SP_MAX;
    end
  end

  assign sts.restart  = target != seen_target;
  assign sts.div_last = dcnt == lst_pkg::DIV_LAST;
  assign sts.mul_done = mplier == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_steps  <= lst_pkg::SHORT_STEPS_RESET;
      medium_steps <= lst_pkg::MEDIUM_STEPS_RESET;
      long_steps   <= lst_pkg::LONG_STEPS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lst_pkg::REG_SHORT:  short_steps  <= cfg_data;
        lst_pkg::REG_MEDIUM: medium_steps <= cfg_data;
        lst_pkg::REG_LONG:   long_steps   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_target      <= '0;
      ramp_start       <= '0;
      current_setpoint <= '0;
      step_increment   <= '0;
      step_count       <= lst_pkg::STEP_COUNT_RESET;
      tick_counter     <= '0;
    end else begin
      if (cmd.prep) begin
        if (sts.restart) begin
          ramp_start   <= current_setpoint;
          seen_target  <= target;
          tick_counter <= '0;
        end else begin
          tick_counter <= tick_next;
        end
      end
      if (cmd.sel) begin
        step_count <= count_sel;
      end
      if (cmd.div_fin) begin
        step_increment <= diff_neg ? (~dq + 1'b1) : dq;
      end
      if (cmd.fin) begin
        current_setpoint <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target <= target_position;
    end
    if (cmd.prep) begin
      diff <= diff_next;
    end
    if (cmd.sel) begin
      diff_neg <= diff[lst_pkg::DIFF_W-1];
      dq       <= mag;
      rem      <= '0;
      dcnt     <= '0;
    end
    if (cmd.div_step) begin
      rem  <= rem_ge ? lst_pkg::STEP_W'(rem_shift - {1'b0, step_count})
                     : lst_pkg::STEP_W'(rem_shift);
      dq   <= {dq[lst_pkg::DIFF_W-2:0], rem_ge};
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.mload) begin
      acc    <= {{(lst_pkg::ACC_W-lst_pkg::SP_W){ramp_start[lst_pkg::SP_W-1]}}, ramp_start};
      mcand  <= {{(lst_pkg::ACC_W-lst_pkg::DIFF_W){step_increment[lst_pkg::DIFF_W-1]}},
                 step_increment};
      mplier <= tick_counter;
    end
    if (cmd.mstep) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[lst_pkg::ACC_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[lst_pkg::STEP_W-1:1]};
    end
    if (cmd.fin) begin
      setpoint   <= sat;
      tick_index <= tick_counter;
    end
  end

endmodule

// ===== hdl/lst_ctrl.sv =====
// Controller of the setpoint trajectory: sequences one tick through the
// datapath and owns the handshakes. Depends on lst_pkg and the assertion header.
`include "linear_setpoint_trajectory_assert.svh"

module lst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lst_pkg::lst_sts_t sts,
  output lst_pkg::lst_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_NEG   = 3'd4;
  localparam logic [2:0] S_MLOAD = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.restart ? S_SEL : S_MLOAD;
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_NEG;
        end
      end
      S_NEG: begin
        cmd.div_fin = 1'b1;
        state_next  = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.mload  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.mul_done) begin
          state_next = S_FIN;
        end else begin
          cmd.mstep = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LST_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd))
  `LST_ASSERT_IMP(a_no_overwrite, out_valid && out_stall, !cmd.fin)
  `LST_ASSERT_NEXT(a_fin_shows, cmd.fin, out_valid)
  `LST_ASSERT_NEXT(a_div_ends, state == S_DIV && sts.div_last, state == S_NEG)

endmodule

// ===== hdl/linear_setpoint_trajectory.sv =====
// Linear setpoint ramp generator: one target position in, one Q.8 setpoint and
// its tick index out per beat. A beat whose target matches the last one seen
// is paced by the shift-add multiplier that walks the significant bits of the
// tick index. A beat with a new target first runs the one-bit-per-cycle divider
// through the 41-bit distance, then the multiplier. One beat is in flight at a
// time; the next one is taken as soon as its result is registered, even while
// that result waits.
module linear_setpoint_trajectory (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [lst_pkg::TGT_W-1:0] target_position,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [lst_pkg::SP_W-1:0]  setpoint,
  output logic [lst_pkg::STEP_W-1:0]       tick_index,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lst_pkg::IDX_W-1:0]        cfg_index,
  input  logic [lst_pkg::STEP_W-1:0]       cfg_data
);

  lst_pkg::lst_cmd_t cmd;
  lst_pkg::lst_sts_t sts;

  assign cfg_ready = 1'b1;

  lst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lst_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .target_position (target_position),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .setpoint        (setpoint),
    .tick_index      (tick_index)
  );

endmodule
